// ===== hdl/dchm_pkg.sv =====
// Shared types and constants for the deauth channel hop monitor.
// Used by every module under hdl; depends on nothing.
package dchm_pkg;

    // Field widths
    localparam int unsigned TimerW   = 16;
    localparam int unsigned TallyW   = 8;
    localparam int unsigned ChanW    = 4;
    localparam int unsigned PassW    = 4;
    localparam int unsigned ByteW    = 8;
    localparam int unsigned ReasonW  = 2;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 16;

    // Frame classification
    localparam logic [ByteW-1:0] DEAUTH_MASK = 8'hF0;
    localparam logic [ByteW-1:0] DEAUTH_CODE = 8'hC0;

    // Saturation limits
    localparam logic [TimerW-1:0] TIMER_MAX = 16'hFFFF;
    localparam logic [TallyW-1:0] TALLY_MAX = 8'hFF;

    // Item kind
    localparam logic FUNC_FRAME = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_INTERVAL  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_QUIET     = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_THRESHOLD = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_TOP_CHAN  = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_PASSES    = 3'd4;

    // Configuration reset values
    localparam logic [TimerW-1:0] RST_INTERVAL  = 16'd1000;
    localparam logic [TimerW-1:0] RST_QUIET     = 16'd30000;
    localparam logic [TallyW-1:0] RST_THRESHOLD = 8'd5;
    localparam logic [ChanW-1:0]  RST_TOP_CHAN  = 4'd13;
    localparam logic [PassW-1:0]  RST_PASSES    = 4'd3;

    // Session end reasons
    localparam logic [ReasonW-1:0] REASON_NONE   = 2'd0;
    localparam logic [ReasonW-1:0] REASON_QUIET  = 2'd1;
    localparam logic [ReasonW-1:0] REASON_THRESH = 2'd2;
    localparam logic [ReasonW-1:0] REASON_PASSES = 2'd3;

    localparam logic [ChanW-1:0] FIRST_CHAN = 4'd1;

    typedef struct packed {
        logic [TimerW-1:0] interval_ms;
        logic [TimerW-1:0] quiet_timeout_ms;
        logic [TallyW-1:0] alert_threshold;
        logic [ChanW-1:0]  top_channel;
        logic [PassW-1:0]  pass_limit;
    } t_cfg;

    typedef struct packed {
        logic             func;
        logic             is_management;
        logic [ByteW-1:0] frame_byte;
    } t_item;

    typedef struct packed {
        logic               sniffing;
        logic [ChanW-1:0]   channel;
        logic               channel_change;
        logic               deauth_detected;
        logic               wake;
        logic [ReasonW-1:0] end_reason;
    } t_result;

endpackage

// ===== hdl/dchm_cfg_regs.sv =====
// Configuration register file for the deauth channel hop monitor.
// Depends on dchm_pkg for the index codes, reset values and t_cfg.
module dchm_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [dchm_pkg::CfgIdxW-1:0]   i_wr_index,
    input  logic [dchm_pkg::CfgDataW-1:0]  i_wr_data,
    output dchm_pkg::t_cfg                 o_cfg
);

    dchm_pkg::t_cfg r_cfg;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.interval_ms      <= dchm_pkg::RST_INTERVAL;
            r_cfg.quiet_timeout_ms <= dchm_pkg::RST_QUIET;
            r_cfg.alert_threshold  <= dchm_pkg::RST_THRESHOLD;
            r_cfg.top_channel      <= dchm_pkg::RST_TOP_CHAN;
            r_cfg.pass_limit       <= dchm_pkg::RST_PASSES;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                dchm_pkg::CFG_INTERVAL:  r_cfg.interval_ms      <= i_wr_data;
                dchm_pkg::CFG_QUIET:     r_cfg.quiet_timeout_ms <= i_wr_data;
                dchm_pkg::CFG_THRESHOLD:
                    r_cfg.alert_threshold <= i_wr_data[dchm_pkg::TallyW-1:0];
                dchm_pkg::CFG_TOP_CHAN:
                    r_cfg.top_channel <= i_wr_data[dchm_pkg::ChanW-1:0];
                dchm_pkg::CFG_PASSES:
                    r_cfg.pass_limit <= i_wr_data[dchm_pkg::PassW-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/dchm_step.sv =====
// Session state and per-item update logic of the deauth channel hop monitor.
// Depends on dchm_pkg for t_cfg, t_item, t_result and constants.
module dchm_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  dchm_pkg::t_cfg    i_cfg,
    input  dchm_pkg::t_item   i_item,
    output dchm_pkg::t_result o_result
);

    logic                         r_active;
    logic [dchm_pkg::ChanW-1:0]   r_chan;
    logic [dchm_pkg::PassW-1:0]   r_passes;
    logic [dchm_pkg::TimerW-1:0]  r_ielapsed;
    logic [dchm_pkg::TimerW-1:0]  r_since;
    logic [dchm_pkg::TallyW-1:0]  r_tally;

    logic                         n_active;
    logic [dchm_pkg::ChanW-1:0]   n_chan;
    logic [dchm_pkg::PassW-1:0]   n_passes;
    logic [dchm_pkg::TimerW-1:0]  n_ielapsed;
    logic [dchm_pkg::TimerW-1:0]  n_since;
    logic [dchm_pkg::TallyW-1:0]  n_tally;

    logic [dchm_pkg::TimerW-1:0]  since_inc;
    logic [dchm_pkg::TimerW-1:0]  ielapsed_inc;
    logic [dchm_pkg::ChanW:0]     chan_up;
    logic [dchm_pkg::PassW-1:0]   passes_up;
    logic                         wrap;
    logic                         is_deauth;
    logic                         change;
    logic                         wake;
    logic [dchm_pkg::ReasonW-1:0] reason;

    // Saturating timer ages and channel/pass increments
    assign since_inc    = (r_since == dchm_pkg::TIMER_MAX) ? r_since : r_since + 1'b1;
    assign ielapsed_inc = (r_ielapsed == dchm_pkg::TIMER_MAX) ? r_ielapsed
                                                              : r_ielapsed + 1'b1;
    assign chan_up   = {1'b0, r_chan} + 1'b1;
    assign passes_up = r_passes + 1'b1;
    assign wrap      = (chan_up > {1'b0, i_cfg.top_channel}) || chan_up[dchm_pkg::ChanW];
    assign is_deauth = i_item.is_management
                    && ((i_item.frame_byte & dchm_pkg::DEAUTH_MASK) == dchm_pkg::DEAUTH_CODE);

    // Next state and result for one item
    always_comb begin
        n_active   = r_active;
        n_chan     = r_chan;
        n_passes   = r_passes;
        n_ielapsed = r_ielapsed;
        n_since    = r_since;
        n_tally    = r_tally;
        change     = 1'b0;
        wake       = 1'b0;
        reason     = dchm_pkg::REASON_NONE;
        if (i_item.func == dchm_pkg::FUNC_FRAME) begin
            if (is_deauth) begin
                n_tally = (r_tally == dchm_pkg::TALLY_MAX) ? r_tally : r_tally + 1'b1;
                n_since = '0;
            end
        end else if (!r_active) begin
            // session start
            n_active   = 1'b1;
            n_passes   = '0;
            n_chan     = dchm_pkg::FIRST_CHAN;
            n_ielapsed = '0;
            n_since    = '0;
            n_tally    = '0;
            change     = 1'b1;
        end else begin
            n_since    = since_inc;
            n_ielapsed = ielapsed_inc;
            priority if (since_inc >= i_cfg.quiet_timeout_ms) begin
                n_active = 1'b0;
                wake     = 1'b1;
                reason   = dchm_pkg::REASON_QUIET;
            end else if (ielapsed_inc >= i_cfg.interval_ms) begin
                if (r_tally >= i_cfg.alert_threshold) begin
                    n_active = 1'b0;
                    wake     = 1'b1;
                    reason   = dchm_pkg::REASON_THRESH;
                end else begin
                    n_tally = '0;
                    if (wrap) begin
                        n_passes = passes_up;
                        n_chan   = dchm_pkg::FIRST_CHAN;
                    end else begin
                        n_chan = chan_up[dchm_pkg::ChanW-1:0];
                    end
                    if (wrap && (passes_up >= i_cfg.pass_limit)) begin
                        n_active = 1'b0;
                        wake     = 1'b1;
                        reason   = dchm_pkg::REASON_PASSES;
                    end else begin
                        change     = 1'b1;
                        n_ielapsed = '0;
                    end
                end
            end else begin
                // keep aging
            end
        end
    end

    // State update on each item that moves to the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_chan     <= dchm_pkg::FIRST_CHAN;
            r_passes   <= '0;
            r_ielapsed <= '0;
            r_since    <= '0;
            r_tally    <= '0;
        end else if (i_advance) begin
            r_active   <= n_active;
            r_chan     <= n_chan;
            r_passes   <= n_passes;
            r_ielapsed <= n_ielapsed;
            r_since    <= n_since;
            r_tally    <= n_tally;
        end
    end

    assign o_result.sniffing        = n_active;
    assign o_result.channel         = n_chan;
    assign o_result.channel_change  = change;
    assign o_result.deauth_detected = (i_item.func == dchm_pkg::FUNC_FRAME) && is_deauth;
    assign o_result.wake            = wake;
    assign o_result.end_reason      = reason;

endmodule

// ===== hdl/deauth_channel_hop_monitor_core.sv =====
// Top level of the deauth channel hop monitor: input register, result register, handshakes.
// Depends on dchm_pkg, dchm_cfg_regs and dchm_step.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------------------
//  cfg     | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//  in      | in        | i_in_valid / o_in_ready    | i_func, i_is_management, i_frame_byte
//  out     | out       | o_out_valid / i_out_ready  | o_sniffing, o_channel, o_channel_change,
//          |           |                            | o_deauth_detected, o_wake, o_end_reason
//
// One item per cycle while the result is not stalled; each item passes the input register, then the
// result register, before its result transaction on the out channel.
// Session state changes when an item moves from the input register to the result register.
// Reset clears both stage valids and the session state; no clearing pass is needed.
// With the result stalled, one more item is held in the input register, then o_in_ready drops.
// Config writes are taken in any cycle (o_cfg_ready is always high).
module deauth_channel_hop_monitor_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dchm_pkg::CfgIdxW-1:0]        i_cfg_index,
    input  logic [dchm_pkg::CfgDataW-1:0]       i_cfg_data,
    // input items
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_func,
    input  logic                                i_is_management,
    input  logic [dchm_pkg::ByteW-1:0]          i_frame_byte,
    // results
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_sniffing,
    output logic [dchm_pkg::ChanW-1:0]          o_channel,
    output logic                                o_channel_change,
    output logic                                o_deauth_detected,
    output logic                                o_wake,
    output logic [dchm_pkg::ReasonW-1:0]        o_end_reason
);

    dchm_pkg::t_cfg    cfg;
    dchm_pkg::t_result step_result;

    logic              r_in_valid;
    dchm_pkg::t_item   r_item;
    logic              r_out_valid;
    dchm_pkg::t_result r_result;

    logic              out_free;
    logic              advance;
    logic              in_take;

    assign o_cfg_ready = 1'b1;

    dchm_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Stage control
    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;
    assign in_take    = i_in_valid && o_in_ready;

    dchm_step u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_cfg     (cfg),
        .i_item    (r_item),
        .o_result  (step_result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.func          <= i_func;
            r_item.is_management <= i_is_management;
            r_item.frame_byte    <= i_frame_byte;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= step_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_sniffing        = r_result.sniffing;
    assign o_channel         = r_result.channel;
    assign o_channel_change  = r_result.channel_change;
    assign o_deauth_detected = r_result.deauth_detected;
    assign o_wake            = r_result.wake;
    assign o_end_reason      = r_result.end_reason;

endmodule
